FILE: src/kmeans_cluster_3d_core_defines.svh
// Assertion macros for the k-means clustering core checker.
// Standalone header, no dependencies.
`ifndef KMEANS_CLUSTER_3D_CORE_DEFINES_SVH
`define KMEANS_CLUSTER_3D_CORE_DEFINES_SVH

// Check a property while out of reset.
`define KMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kmc3 check failed");

// Check a property on every edge, reset included.
`define KMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kmc3 check failed");

`endif

FILE: src/kmc3_pkg.sv
// Shared types and constants for the k-means clustering core.
// No dependencies.
package kmc3_pkg;

  localparam int MAX_POINTS_DEF   = 16384;
  localparam int MAX_CLUSTERS_DEF = 8;
  localparam int COORD_W          = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 2'd1;

  localparam logic [3:0]  NUM_CLUSTERS_RST = 4'd3;
  localparam logic [15:0] ITER_LIMIT_RST   = 16'd1999;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_SEED_RD, S_SEED_WR, S_ITER, S_PT_RD, S_SQ, S_CMP,
    S_ACC, S_DIV, S_DIVW, S_ITEND, S_EMIT, S_OUT
  } state_t;

endpackage

FILE: src/kmc3_ptmem.sv
// Point store and assignment store, registered read.
// Depends on kmc3_pkg.
module kmc3_ptmem #(
  parameter int DEPTH = kmc3_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = 3
) (
  input  logic                 clk,
  input  logic                 pt_we,
  input  logic [AW-1:0]        pt_wa,
  input  kmc3_pkg::point_t     pt_wd,
  input  logic                 asg_we,
  input  logic [AW-1:0]        asg_wa,
  input  logic [CW-1:0]        asg_wd,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output kmc3_pkg::point_t     rd_pt,
  output logic [CW-1:0]        rd_asg
);

  kmc3_pkg::point_t pt_mem [DEPTH];
  logic [CW-1:0]    asg_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (rd_en) begin
      rd_pt <= pt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[asg_wa] <= asg_wd;
    end
    if (rd_en) begin
      rd_asg <= asg_mem[rd_addr];
    end
  end

endmodule

FILE: src/kmc3_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on kmc3_pkg.
module kmc3_div #(
  parameter int DW = 32,
  parameter int VW = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [DW-1:0]                dividend,
  input  logic [VW-1:0]                       divisor,
  output logic                                done,
  output logic signed [kmc3_pkg::COORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    mag_r, mag_nxt;
  logic [VW:0]      rem_r, rem_nxt;
  logic [VW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [VW+1:0]    rem_sh;
  logic [DW-1:0]    q_signed;

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, mag_r[DW-1]};
    if (start) begin
      neg_nxt  = dividend[DW-1];
      mag_nxt  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (rem_sh >= {2'b00, den_r}) begin
        rem_nxt = (VW+1)'(rem_sh - {2'b00, den_r});
        mag_nxt = {mag_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[VW:0];
        mag_nxt = {mag_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? DW'(-mag_r) : mag_r;
  assign quotient = q_signed[kmc3_pkg::COORD_W-1:0];
  assign done     = done_r;

endmodule

FILE: src/kmeans_cluster_3d_core.sv
// Lloyd k-means over streamed 3-D points: top level with sequencer.
// Depends on kmc3_pkg, kmc3_ptmem, kmc3_div.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | point_x/y/z, final_point
//  out_    | output    | out_valid/out_stall| cluster results, or one error result
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Loading takes one point per cycle. A run then seeds the centroids from the first K
// points and per iteration assigns each point (a point read, a square and a compare
// step per centroid in the shared distance unit, an accumulate step), then does
// three divisions per non-empty cluster in the serial divider; empty clusters are
// skipped. Results are held while out_stall. Reset clears control state only; stores
// need no clearing pass. Input is stalled for the whole run and while results wait.
module kmeans_cluster_3d_core #(
  parameter int MAX_POINTS   = kmc3_pkg::MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = kmc3_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [15:0]                   in_point_x,
  input  logic signed [15:0]                   in_point_y,
  input  logic signed [15:0]                   in_point_z,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_cluster_index,
  output logic signed [15:0]                   out_center_x,
  output logic signed [15:0]                   out_center_y,
  output logic signed [15:0]                   out_center_z,
  output logic [14:0]                          out_member_count,
  output logic [15:0]                          out_iterations_done,
  output logic                                 out_converged,
  output logic                                 out_error,
  output logic                                 out_last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kmc3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmc3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int N_W   = $clog2(MAX_POINTS + 1);
  localparam int CL_W  = $clog2(MAX_CLUSTERS);
  localparam int K_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W = kmc3_pkg::COORD_W + N_W;
  localparam int DW    = kmc3_pkg::DIST_W;
  localparam int SQW   = kmc3_pkg::SQ_W;

  kmc3_pkg::state_t st_r, st_nxt;

  // configuration registers
  logic [3:0]  ncl_r;
  logic [15:0] lim_r;
  logic [K_W-1:0] k_eff;

  logic [N_W-1:0]  n_r, n_nxt;
  logic [N_W-1:0]  i_r, i_nxt;
  logic [CL_W-1:0] j_r, j_nxt;
  logic [1:0]      d_r, d_nxt;
  logic [15:0]     iter_r, iter_nxt;
  logic            first_r, first_nxt;
  logic            chg_r, chg_nxt;
  logic            conv_r, conv_nxt;
  logic [CL_W-1:0] best_r, best_nxt;
  logic [DW-1:0]   bestd_r, bestd_nxt;
  logic [SQW-1:0]  sq_r [3];
  logic            j_last;

  kmc3_pkg::point_t       cent_r [MAX_CLUSTERS];
  logic signed [SUM_W-1:0] sums_r [MAX_CLUSTERS][3];
  logic [N_W-1:0]         cnt_r  [MAX_CLUSTERS];

  // strobes from the sequencer
  logic pt_we, rd_en, asg_we, clr_acc, acc_en, seed_we, cdiv_we, sq_en;
  logic div_start, out_load, err_load;
  logic [PT_W-1:0] rd_addr;
  kmc3_pkg::point_t rd_pt;
  logic [CL_W-1:0]  rd_asg;
  kmc3_pkg::point_t in_pt;

  logic signed [kmc3_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [DW-1:0] dist_sum;

  logic signed [SUM_W-1:0]              div_num;
  logic                                 div_done;
  logic signed [kmc3_pkg::COORD_W-1:0]  div_q;

  // output register
  logic        out_valid_r;
  logic [2:0]  o_idx_r;
  kmc3_pkg::point_t o_c_r;
  logic [14:0] o_cnt_r;
  logic [15:0] o_it_r;
  logic        o_conv_r, o_err_r, o_last_r;

  // clamp K into 1..MAX_CLUSTERS
  always_comb begin
    if (ncl_r == 4'd0) begin
      k_eff = K_W'(1);
    end else if (32'(ncl_r) > MAX_CLUSTERS) begin
      k_eff = K_W'(MAX_CLUSTERS);
    end else begin
      k_eff = K_W'(ncl_r);
    end
  end

  assign j_last = (K_W'(j_r) + K_W'(1)) == k_eff;
  assign in_pt  = '{x: in_point_x, y: in_point_y, z: in_point_z};

  // configuration: always ready; write only while the core is idle
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r <= kmc3_pkg::NUM_CLUSTERS_RST;
      lim_r <= kmc3_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kmc3_pkg::CFG_NUM_CLUSTERS: ncl_r <= cfg_data[3:0];
        kmc3_pkg::CFG_ITER_LIMIT:   lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  kmc3_ptmem #(.DEPTH(MAX_POINTS), .AW(PT_W), .CW(CL_W)) u_mem (
    .clk    (clk),
    .pt_we  (pt_we),
    .pt_wa  (n_r[PT_W-1:0]),
    .pt_wd  (in_pt),
    .asg_we (asg_we),
    .asg_wa (i_r[PT_W-1:0]),
    .asg_wd (best_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_pt  (rd_pt),
    .rd_asg (rd_asg)
  );

  // distance unit: squares registered, summed on the next cycle
  assign dx = kmc3_pkg::DIFF_W'(rd_pt.x) - kmc3_pkg::DIFF_W'(cent_r[j_r].x);
  assign dy = kmc3_pkg::DIFF_W'(rd_pt.y) - kmc3_pkg::DIFF_W'(cent_r[j_r].y);
  assign dz = kmc3_pkg::DIFF_W'(rd_pt.z) - kmc3_pkg::DIFF_W'(cent_r[j_r].z);
  assign dist_sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (sq_en) begin
      sq_r[0] <= SQW'(dx * dx);
      sq_r[1] <= SQW'(dy * dy);
      sq_r[2] <= SQW'(dz * dz);
    end
  end

  always_comb begin
    case (d_r)
      2'd0:    div_num = sums_r[j_r][0];
      2'd1:    div_num = sums_r[j_r][1];
      default: div_num = sums_r[j_r][2];
    endcase
  end

  kmc3_div #(.DW(SUM_W), .VW(N_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (cnt_r[j_r]),
    .done    (div_done),
    .quotient(div_q)
  );

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    d_nxt     = d_r;
    iter_nxt  = iter_r;
    first_nxt = first_r;
    chg_nxt   = chg_r;
    conv_nxt  = conv_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    in_stall  = 1'b1;
    pt_we     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = i_r[PT_W-1:0];
    asg_we    = 1'b0;
    clr_acc   = 1'b0;
    acc_en    = 1'b0;
    seed_we   = 1'b0;
    cdiv_we   = 1'b0;
    sq_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    err_load  = 1'b0;
    case (st_r)
      kmc3_pkg::S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // drop points beyond the store
          if (32'(n_r) < MAX_POINTS) begin
            pt_we = 1'b1;
            n_nxt = n_r + 1'b1;
          end
          if (in_final_point) begin
            st_nxt = kmc3_pkg::S_START;
          end
        end
      end
      kmc3_pkg::S_START: begin
        iter_nxt  = '0;
        conv_nxt  = 1'b0;
        first_nxt = 1'b1;
        clr_acc   = 1'b1;
        j_nxt     = '0;
        if (32'(n_r) < 32'(k_eff)) begin
          err_load = 1'b1;
          st_nxt   = kmc3_pkg::S_OUT;
        end else begin
          st_nxt = kmc3_pkg::S_SEED_RD;
        end
      end
      kmc3_pkg::S_SEED_RD: begin
        rd_en   = 1'b1;
        rd_addr = PT_W'(j_r);
        st_nxt  = kmc3_pkg::S_SEED_WR;
      end
      kmc3_pkg::S_SEED_WR: begin
        seed_we = 1'b1;
        if (j_last) begin
          st_nxt = kmc3_pkg::S_ITER;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = kmc3_pkg::S_SEED_RD;
        end
      end
      kmc3_pkg::S_ITER: begin
        j_nxt = '0;
        if (iter_r < lim_r) begin
          clr_acc = 1'b1;
          chg_nxt = first_r;
          i_nxt   = '0;
          st_nxt  = kmc3_pkg::S_PT_RD;
        end else begin
          st_nxt = kmc3_pkg::S_EMIT;
        end
      end
      kmc3_pkg::S_PT_RD: begin
        rd_en  = 1'b1;
        j_nxt  = '0;
        st_nxt = kmc3_pkg::S_SQ;
      end
      kmc3_pkg::S_SQ: begin
        sq_en  = 1'b1;
        st_nxt = kmc3_pkg::S_CMP;
      end
      kmc3_pkg::S_CMP: begin
        // strict compare keeps the lower index on ties
        if (j_r == '0 || dist_sum < bestd_r) begin
          best_nxt  = j_r;
          bestd_nxt = dist_sum;
        end
        if (j_last) begin
          st_nxt = kmc3_pkg::S_ACC;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = kmc3_pkg::S_SQ;
        end
      end
      kmc3_pkg::S_ACC: begin
        asg_we = 1'b1;
        acc_en = 1'b1;
        if (!first_r && rd_asg != best_r) begin
          chg_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == n_r) begin
          j_nxt  = '0;
          d_nxt  = '0;
          st_nxt = kmc3_pkg::S_DIV;
        end else begin
          st_nxt = kmc3_pkg::S_PT_RD;
        end
      end
      kmc3_pkg::S_DIV: begin
        if (cnt_r[j_r] == '0) begin
          // empty cluster keeps its centroid
          if (j_last) begin
            st_nxt = kmc3_pkg::S_ITEND;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          div_start = 1'b1;
          st_nxt    = kmc3_pkg::S_DIVW;
        end
      end
      kmc3_pkg::S_DIVW: begin
        if (div_done) begin
          cdiv_we = 1'b1;
          if (d_r == 2'd2) begin
            d_nxt = '0;
            if (j_last) begin
              st_nxt = kmc3_pkg::S_ITEND;
            end else begin
              j_nxt  = j_r + 1'b1;
              st_nxt = kmc3_pkg::S_DIV;
            end
          end else begin
            d_nxt  = d_r + 1'b1;
            st_nxt = kmc3_pkg::S_DIV;
          end
        end
      end
      kmc3_pkg::S_ITEND: begin
        iter_nxt  = iter_r + 1'b1;
        first_nxt = 1'b0;
        j_nxt     = '0;
        if (!chg_r) begin
          conv_nxt = 1'b1;
          st_nxt   = kmc3_pkg::S_EMIT;
        end else begin
          st_nxt = kmc3_pkg::S_ITER;
        end
      end
      kmc3_pkg::S_EMIT: begin
        out_load = 1'b1;
        st_nxt   = kmc3_pkg::S_OUT;
      end
      kmc3_pkg::S_OUT: begin
        if (!out_stall) begin
          if (o_last_r) begin
            n_nxt  = '0;
            st_nxt = kmc3_pkg::S_LOAD;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = kmc3_pkg::S_EMIT;
          end
        end
      end
      default: st_nxt = kmc3_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= kmc3_pkg::S_LOAD;
      n_r     <= '0;
      iter_r  <= '0;
      first_r <= 1'b1;
      chg_r   <= 1'b0;
      conv_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      n_r     <= n_nxt;
      iter_r  <= iter_nxt;
      first_r <= first_nxt;
      chg_r   <= chg_nxt;
      conv_r  <= conv_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    d_r     <= d_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
  end

  // accumulators: clear at iteration start, add the point to its winner
  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      if (clr_acc) begin
        cnt_r[c] <= '0;
        for (int a = 0; a < 3; a++) begin
          sums_r[c][a] <= '0;
        end
      end else if (acc_en && best_r == CL_W'(c)) begin
        cnt_r[c]     <= cnt_r[c] + 1'b1;
        sums_r[c][0] <= sums_r[c][0] + SUM_W'(rd_pt.x);
        sums_r[c][1] <= sums_r[c][1] + SUM_W'(rd_pt.y);
        sums_r[c][2] <= sums_r[c][2] + SUM_W'(rd_pt.z);
      end
    end
  end

  // centroids: seed from the first K points, then take the means
  always_ff @(posedge clk) begin
    if (seed_we) begin
      cent_r[j_r] <= rd_pt;
    end else if (cdiv_we) begin
      case (d_r)
        2'd0:    cent_r[j_r].x <= div_q;
        2'd1:    cent_r[j_r].y <= div_q;
        default: cent_r[j_r].z <= div_q;
      endcase
    end
  end

  // result register; hold while out_stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load || err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (err_load) begin
      o_idx_r  <= '0;
      o_c_r    <= '0;
      o_cnt_r  <= '0;
      o_it_r   <= '0;
      o_conv_r <= 1'b0;
      o_err_r  <= 1'b1;
      o_last_r <= 1'b1;
    end else if (out_load) begin
      o_idx_r  <= 3'(j_r);
      o_c_r    <= cent_r[j_r];
      o_cnt_r  <= 15'(cnt_r[j_r]);
      o_it_r   <= iter_r;
      o_conv_r <= conv_r;
      o_err_r  <= 1'b0;
      o_last_r <= j_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cluster_index   = o_idx_r;
  assign out_center_x        = o_c_r.x;
  assign out_center_y        = o_c_r.y;
  assign out_center_z        = o_c_r.z;
  assign out_member_count    = o_cnt_r;
  assign out_iterations_done = o_it_r;
  assign out_converged       = o_conv_r;
  assign out_error           = o_err_r;
  assign out_last_result     = o_last_r;

endmodule

FILE: src/kmc3_checker.sv
// Port-level checker for the k-means clustering core, bound to the top.
// Depends on kmeans_cluster_3d_core_defines.svh.
`include "kmeans_cluster_3d_core_defines.svh"
module kmc3_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [2:0]                      out_cluster_index,
  input logic [14:0]                     out_member_count,
  input logic                            out_converged,
  input logic                            out_error,
  input logic                            out_last_result
);

  `KMC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cluster_index))
  `KMC_ASSERT(a_no_load_while_result, out_valid |-> in_stall)
  `KMC_ASSERT(a_err_last, out_valid && out_error |-> out_last_result && out_member_count == 0)
  `KMC_ASSERT(a_err_no_conv, out_valid && out_error |-> !out_converged)
  `KMC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind kmeans_cluster_3d_core kmc3_checker u_kmc3_checker (.*);
